@@ sv/haversine_distance_assert.svh @@
// Assertion macros for the haversine distance block
`ifndef HAVERSINE_DISTANCE_ASSERT_SVH
`define HAVERSINE_DISTANCE_ASSERT_SVH

// checked only while out of reset
`define HAV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define HAV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/hav_pkg.sv @@
// Shared types, constants and arctangent table for the haversine distance block
package hav_pkg;

  localparam int CORDIC_STAGES_DEF = 32;
  localparam int CORDIC_W          = 34;
  localparam int SQRT_STEPS        = 31;
  localparam int SQRT_W            = 62;
  localparam int FIFO_DEPTH_DEF    = 4;

  localparam logic signed [30:0] LAT_LIMIT       = 31'sd900000000;
  localparam logic signed [32:0] TURN_UNITS      = 33'sd3600000000;
  localparam logic signed [32:0] HALF_TURN_UNITS = 33'sd1800000000;
  // round(pi * 2^60 / 3.6e9): 1e-7 degree to half an angle in Q2.30 radians
  localparam logic [29:0]        DEG_TO_HALF_RAD = 30'd1006113814;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sh0_26DD_3B6A;
  localparam logic [30:0]        Q30_ONE         = 31'h4000_0000;
  localparam logic [29:0]        EARTH_RADIUS_CM = 30'd637100000;
  localparam logic [30:0]        DIST_MAX        = 31'd2001600000;

  typedef struct packed {
    logic signed [31:0] dlat_h;   // (target - current latitude) / 2
    logic signed [31:0] dlon_h;   // wrapped longitude difference / 2
    logic signed [31:0] clat;     // current latitude
    logic signed [31:0] tlat;     // target latitude
  } front_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic [31:0] atan_q30(input int unsigned idx);
    logic [31:0] v;
    unique case (idx)
      0:       v = 32'h3243F6A8;
      1:       v = 32'h1DAC6705;
      2:       v = 32'h0FADBAFC;
      3:       v = 32'h07F56EA6;
      4:       v = 32'h03FEAB76;
      5:       v = 32'h01FFD55B;
      6:       v = 32'h00FFFAAA;
      7:       v = 32'h007FFF55;
      8:       v = 32'h003FFFEA;
      9:       v = 32'h001FFFFD;
      10:      v = 32'h000FFFFF;
      11:      v = 32'h0007FFFF;
      12:      v = 32'h0003FFFF;
      13:      v = 32'h0001FFFF;
      14:      v = 32'h0000FFFF;
      15:      v = 32'h00007FFF;
      16:      v = 32'h00003FFF;
      17:      v = 32'h00001FFF;
      18:      v = 32'h00000FFF;
      19:      v = 32'h000007FF;
      20:      v = 32'h000003FF;
      21:      v = 32'h000001FF;
      22:      v = 32'h000000FF;
      23:      v = 32'h0000007F;
      24:      v = 32'h0000003F;
      25:      v = 32'h0000001F;
      26:      v = 32'h0000000F;
      27:      v = 32'h00000007;
      28:      v = 32'h00000003;
      29:      v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

@@ sv/haversine_distance.sv @@
// Top level of the haversine great-circle distance block
// Takes one pair of positions per transfer and returns the great-circle distance
// in centimetres on a 6371 km sphere, saturated at 2001600000. The block accepts
// a new position pair every cycle while in_tready is high. Results pass through the
// two unrolled CORDIC pipelines (trig, then atan2) and the 31-stage square-root
// pipeline. The front end and back end are parted by a FIFO_DEPTH-entry queue, so
// input stays ready through a short stall at the output; a longer stall fills the
// queue and then drops in_tready.
module haversine_distance #(
  parameter int CORDIC_STAGES = hav_pkg::CORDIC_STAGES_DEF,
  parameter int FIFO_DEPTH    = hav_pkg::FIFO_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // current_lat[30:0], current_lon[62:31], target_lat[93:63], target_lon[125:94]
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // distance_cm[30:0]
  output logic [31:0]  out_tdata
);
  import hav_pkg::*;

  logic         f_valid;
  front_item_t  f_item;
  logic [127:0] q_data;
  front_item_t  q_item;
  logic         q_ready;
  fifo_status_t fifo_st;

  hav_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .item_valid (f_valid),
    .item       (f_item),
    .item_ready (!fifo_st.full)
  );

  hav_fifo #(.WIDTH($bits(front_item_t)), .DEPTH(FIFO_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_data (f_item),
    .pop       (q_ready),
    .pop_data  (q_data),
    .status    (fifo_st)
  );

  assign q_item = q_data;

  hav_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (!fifo_st.empty),
    .item       (q_item),
    .item_ready (q_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`include "haversine_distance_assert.svh"

  `HAV_ASSERT(a_stall_only_when_full, !in_tready |-> fifo_st.full, "input stalled with queue space")
  `HAV_ASSERT(a_queue_drains, (out_tready && !fifo_st.empty) |-> q_ready, "queue not drained")
  `HAV_ASSERT(a_dist_range, out_tvalid |-> (out_tdata[30:0] <= DIST_MAX), "distance over limit")
  `HAV_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

@@ sv/hav_front.sv @@
// Front end: accepts positions, clamps, wraps and converts to Q2.30 radians, halving the differences
module hav_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // current_lat[30:0], current_lon[62:31], target_lat[93:63], target_lon[125:94]
  input  logic [127:0]        in_tdata,
  output logic                item_valid,
  output hav_pkg::front_item_t item,
  input  logic                item_ready
);
  import hav_pkg::*;

  localparam int NSTG = 6;

  logic               en;
  logic [NSTG-1:0]    vld_r;

  logic signed [30:0] in_clat, in_tlat;
  logic signed [31:0] in_clon, in_tlon;

  logic signed [30:0] clat1_r, clat1_nxt, tlat1_r, tlat1_nxt;
  logic signed [32:0] dlon1_r, dlon1_nxt;
  logic signed [32:0] ang2_r [4];
  logic signed [32:0] ang2_nxt [4];
  logic signed [32:0] ang3_r [4];
  logic signed [32:0] ang3_nxt [4];
  logic [32:0]        abs3 [4];
  logic [30:0]        mag4_r [4];
  logic [30:0]        mag4_nxt [4];
  logic [3:0]         neg4_r, neg4_nxt, neg5_r;
  logic [60:0]        prod5_r [4];
  logic [60:0]        prod5_nxt [4];
  logic [60:0]        rnd6 [4];
  logic signed [31:0] half6 [4];
  front_item_t        item_r, item_nxt;

  function automatic logic signed [30:0] clamp_lat(input logic signed [30:0] v);
    if (v > LAT_LIMIT) return LAT_LIMIT;
    if (v < -LAT_LIMIT) return -LAT_LIMIT;
    return v;
  endfunction

  assign in_clat = in_tdata[30:0];
  assign in_clon = in_tdata[62:31];
  assign in_tlat = in_tdata[93:63];
  assign in_tlon = in_tdata[125:94];

  assign en        = !vld_r[NSTG-1] || item_ready;
  assign in_tready = en;

  always_comb begin
    clat1_nxt = clamp_lat(in_clat);
    tlat1_nxt = clamp_lat(in_tlat);
    dlon1_nxt = {in_tlon[31], in_tlon} - {in_clon[31], in_clon};
  end

  always_comb begin
    ang2_nxt[0] = {{2{tlat1_r[30]}}, tlat1_r} - {{2{clat1_r[30]}}, clat1_r};
    // the raw difference is within two turns, so one step does the modulo
    if (dlon1_r >= TURN_UNITS) begin
      ang2_nxt[1] = dlon1_r - TURN_UNITS;
    end else if (dlon1_r <= -TURN_UNITS) begin
      ang2_nxt[1] = dlon1_r + TURN_UNITS;
    end else begin
      ang2_nxt[1] = dlon1_r;
    end
    ang2_nxt[2] = {clat1_r[30], clat1_r, 1'b0};
    ang2_nxt[3] = {tlat1_r[30], tlat1_r, 1'b0};
  end

  always_comb begin
    for (int k = 0; k < 4; k++) ang3_nxt[k] = ang2_r[k];
    if (ang2_r[1] > HALF_TURN_UNITS) begin
      ang3_nxt[1] = ang2_r[1] - TURN_UNITS;
    end else if (ang2_r[1] < -HALF_TURN_UNITS) begin
      ang3_nxt[1] = ang2_r[1] + TURN_UNITS;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      neg4_nxt[k] = ang3_r[k][32];
      abs3[k]     = ang3_r[k][32] ? 33'(-ang3_r[k]) : 33'(ang3_r[k]);
      mag4_nxt[k] = abs3[k][30:0];
      prod5_nxt[k] = 61'(mag4_r[k]) * 61'(DEG_TO_HALF_RAD);
      rnd6[k]     = prod5_r[k] + (61'd1 << 29);
      half6[k]    = neg5_r[k] ? -$signed({1'b0, rnd6[k][60:30]})
                              : $signed({1'b0, rnd6[k][60:30]});
    end
    item_nxt.dlat_h = half6[0];
    item_nxt.dlon_h = half6[1];
    item_nxt.clat   = half6[2];
    item_nxt.tlat   = half6[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clat1_r <= clat1_nxt;
      tlat1_r <= tlat1_nxt;
      dlon1_r <= dlon1_nxt;
      ang2_r  <= ang2_nxt;
      ang3_r  <= ang3_nxt;
      mag4_r  <= mag4_nxt;
      neg4_r  <= neg4_nxt;
      prod5_r <= prod5_nxt;
      neg5_r  <= neg4_r;
      item_r  <= item_nxt;
    end
  end

  assign item_valid = vld_r[NSTG-1];
  assign item       = item_r;

endmodule

@@ sv/hav_fifo.sv @@
// Short queue between front and back end
module hav_fifo #(
  parameter int WIDTH = 128,
  parameter int DEPTH = hav_pkg::FIFO_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      pop_data,
  output hav_pkg::fifo_status_t status
);
  import hav_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

@@ sv/hav_cordic.sv @@
// Unrolled CORDIC pipeline, rotation or vectoring mode
module hav_cordic #(
  parameter int STAGES = hav_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 vectoring,
  input  logic                                 in_valid,
  input  logic signed [hav_pkg::CORDIC_W-1:0]  in_x,
  input  logic signed [hav_pkg::CORDIC_W-1:0]  in_y,
  input  logic signed [hav_pkg::CORDIC_W-1:0]  in_z,
  output logic                                 out_valid,
  output logic signed [hav_pkg::CORDIC_W-1:0]  out_x,
  output logic signed [hav_pkg::CORDIC_W-1:0]  out_y,
  output logic signed [hav_pkg::CORDIC_W-1:0]  out_z
);
  import hav_pkg::*;

  logic signed [CORDIC_W-1:0] x_r [STAGES];
  logic signed [CORDIC_W-1:0] y_r [STAGES];
  logic signed [CORDIC_W-1:0] z_r [STAGES];
  logic [STAGES-1:0]          vld_r;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [CORDIC_W-1:0] x_i, y_i, z_i, dx, dy, ang;
    logic signed [CORDIC_W-1:0] x_nxt, y_nxt, z_nxt;
    logic                       fwd;

    if (i == 0) begin : g_head
      assign x_i = in_x;
      assign y_i = in_y;
      assign z_i = in_z;
    end else begin : g_body
      assign x_i = x_r[i-1];
      assign y_i = y_r[i-1];
      assign z_i = z_r[i-1];
    end

    assign dx  = y_i >>> i;
    assign dy  = x_i >>> i;
    assign ang = CORDIC_W'(atan_q30(i));
    // fwd: turn by +angle; vectoring drives y towards zero
    assign fwd = vectoring ? (y_i[CORDIC_W-1] || (y_i == '0)) : !z_i[CORDIC_W-1];

    always_comb begin
      if (fwd) begin
        x_nxt = x_i - dx;
        y_nxt = y_i + dy;
        z_nxt = z_i - ang;
      end else begin
        x_nxt = x_i + dx;
        y_nxt = y_i - dy;
        z_nxt = z_i + ang;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STAGES-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_x     = x_r[STAGES-1];
  assign out_y     = y_r[STAGES-1];
  assign out_z     = z_r[STAGES-1];

endmodule

@@ sv/hav_isqrt.sv @@
// Pipelined restoring floor square root of a Q1.60 value, one result bit per stage
module hav_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [60:0] in_n,
  output logic        out_valid,
  output logic [30:0] out_root
);
  import hav_pkg::*;

  logic [60:0]        n_r   [SQRT_STEPS];
  logic [SQRT_W-1:0]  res_r [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] vld_r;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (60 - 2 * k);
    logic [60:0]       n_i, n_nxt;
    logic [SQRT_W-1:0] res_i, res_nxt, trial;

    if (k == 0) begin : g_head
      assign n_i   = in_n;
      assign res_i = '0;
    end else begin : g_body
      assign n_i   = n_r[k-1];
      assign res_i = res_r[k-1];
    end

    assign trial = res_i + BIT;

    always_comb begin
      if (SQRT_W'(n_i) >= trial) begin
        n_nxt   = n_i - trial[60:0];
        res_nxt = (res_i >> 1) + BIT;
      end else begin
        n_nxt   = n_i;
        res_nxt = res_i >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]   <= n_nxt;
        res_r[k] <= res_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQRT_STEPS-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[SQRT_STEPS-1];
  assign out_root  = res_r[SQRT_STEPS-1][30:0];

endmodule

@@ sv/hav_back.sv @@
// Back end: trig, haversine term, square roots, atan2 and scaling to centimetres
module hav_back #(
  parameter int CORDIC_STAGES = hav_pkg::CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  hav_pkg::front_item_t item,
  output logic                 item_ready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata    // distance_cm[30:0]
);
  import hav_pkg::*;

  logic en;

  // four rotation lanes: sin(dlat/2), sin(dlon/2), cos(clat), cos(tlat)
  logic signed [CORDIC_W-1:0] lane_z [4];
  logic signed [CORDIC_W-1:0] lane_x [4];
  logic signed [CORDIC_W-1:0] lane_y [4];
  logic signed [CORDIC_W-1:0] lane_zo [4];
  logic [3:0]                 lane_v;

  logic signed [31:0] s1, s2, c1s, c2s;
  logic [31:0]        c1, c2;
  logic signed [63:0] sq1_r, sq1_nxt, sq2_r, sq2_nxt;
  logic [63:0]        tp_r, tp_nxt;
  logic [31:0]        sa_r, sa_nxt;
  logic [63:0]        m2_r, m2_nxt;
  logic [32:0]        a_sum;
  logic [30:0]        a_r, a_nxt;
  logic [2:0]         vb_r;

  logic        ra_v, rb_v;
  logic [30:0] ra, rb;

  logic                       vec_v;
  logic signed [CORDIC_W-1:0] vec_x, vec_y, vec_z;

  logic [32:0] c_r, c_nxt;
  logic [62:0] prod_r, prod_nxt, rnd;
  logic [1:0]  ve_r;
  logic [30:0] dist_nxt, dist_r;
  logic        out_valid_r;

  assign en         = !out_valid_r || out_tready;
  assign item_ready = en;

  assign lane_z[0] = CORDIC_W'(item.dlat_h);
  assign lane_z[1] = CORDIC_W'(item.dlon_h);
  assign lane_z[2] = CORDIC_W'(item.clat);
  assign lane_z[3] = CORDIC_W'(item.tlat);

  for (genvar l = 0; l < 4; l++) begin : g_lane
    hav_cordic #(.STAGES(CORDIC_STAGES)) u_rot (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .vectoring (1'b0),
      .in_valid  (item_valid),
      .in_x      (CORDIC_GAIN),
      .in_y      ('0),
      .in_z      (lane_z[l]),
      .out_valid (lane_v[l]),
      .out_x     (lane_x[l]),
      .out_y     (lane_y[l]),
      .out_z     (lane_zo[l])
    );
  end

  always_comb begin
    s1  = lane_y[0][31:0];
    s2  = lane_y[1][31:0];
    c1s = lane_x[2][31:0];
    c2s = lane_x[3][31:0];
    // CORDIC error can push a cosine near the pole just below zero
    c1  = c1s[31] ? '0 : c1s;
    c2  = c2s[31] ? '0 : c2s;
    sq1_nxt = s1 * s1;
    sq2_nxt = s2 * s2;
    tp_nxt  = 64'(c1) * 64'(c2);
    sa_nxt  = sq1_r[61:30];
    m2_nxt  = 64'(tp_r[61:30]) * 64'(sq2_r[61:30]);
    a_sum   = 33'(sa_r) + 33'(m2_r[61:30]);
    a_nxt   = (a_sum > 33'(Q30_ONE)) ? Q30_ONE : a_sum[30:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq1_r <= sq1_nxt;
      sq2_r <= sq2_nxt;
      tp_r  <= tp_nxt;
      sa_r  <= sa_nxt;
      m2_r  <= m2_nxt;
      a_r   <= a_nxt;
    end
  end

  hav_isqrt u_sqrt_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vb_r[2]),
    .in_n      ({a_r, 30'd0}),
    .out_valid (ra_v),
    .out_root  (ra)
  );

  hav_isqrt u_sqrt_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vb_r[2]),
    .in_n      ({Q30_ONE - a_r, 30'd0}),
    .out_valid (rb_v),
    .out_root  (rb)
  );

  hav_cordic #(.STAGES(CORDIC_STAGES)) u_atan (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vectoring (1'b1),
    .in_valid  (ra_v && rb_v),
    .in_x      (CORDIC_W'(rb)),
    .in_y      (CORDIC_W'(ra)),
    .in_z      ('0),
    .out_valid (vec_v),
    .out_x     (vec_x),
    .out_y     (vec_y),
    .out_z     (vec_z)
  );

  always_comb begin
    // central angle 2*z, negative taken as zero
    c_nxt    = vec_z[CORDIC_W-1] ? '0 : {vec_z[31:0], 1'b0};
    prod_nxt = 63'(c_r) * 63'(EARTH_RADIUS_CM);
    rnd      = prod_r + (63'd1 << 29);
    dist_nxt = (rnd[62:30] > 33'(DIST_MAX)) ? DIST_MAX : rnd[60:30];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r    <= c_nxt;
      prod_r <= prod_nxt;
      dist_r <= dist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r        <= '0;
      ve_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vb_r        <= {vb_r[1:0], &lane_v};
      ve_r        <= {ve_r[0], vec_v && (vec_x != '0 || vec_y != '0 || 1'b1)};
      out_valid_r <= ve_r[1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, dist_r};

endmodule
